// ===== sv/qthb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qthb_pkg
// Shared types and constants for the quadtree height bounds block.
// ----------------------------------------------------------------------------
package qthb_pkg;

   localparam int FIELD_DIM = 1024;   // heightfield edge in pixels
   localparam int LEAF_DIM  = 32;     // edge of a deepest-level node in pixels

   localparam logic [1:0] REQ_WRITE = 2'd0;
   localparam logic [1:0] REQ_QUERY = 2'd1;
   localparam logic [1:0] REQ_CLEAR = 2'd2;
   localparam logic [1:0] REQ_NOP   = 2'd3;

   localparam logic [15:0] HEIGHT_MAX = 16'hFFFF;
   localparam logic [35:0] SUM_MAX    = 36'hF_FFFF_FFFF;
   localparam logic [31:0] AVG_MAX    = 32'hFFFF_0000;

   // controller -> datapath commands
   typedef struct packed {
      logic load;       // capture request fields
      logic clr_start;  // reset sweep address
      logic clr_step;   // write reset values, advance sweep
      logic rd;         // issue read at current level
      logic wr;         // write back merged stats
      logic lvl_next;   // advance level
      logic q_rd;       // issue query read
      logic q_done;     // register query result
   } dp_cmd_type;

   // datapath -> controller status
   typedef struct packed {
      logic clr_last;
      logic lvl_last;
      logic pix_ok;
   } dp_sts_type;

endpackage : qthb_pkg
`default_nettype wire

// ===== sv/qthb_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qthb_datapath
// Node stores, per-level read-modify-write, clear sweep and query formatting.
// ----------------------------------------------------------------------------
module qthb_datapath (
   input  wire                    clock,
   input  wire                    reset,
   input  qthb_pkg::dp_cmd_type   cmd,
   output qthb_pkg::dp_sts_type   sts,
   input  wire [9:0]              req_pixel_x,
   input  wire [9:0]              req_pixel_y,
   input  wire [15:0]             req_height,
   input  wire [2:0]              req_level,
   input  wire [4:0]              req_node_x,
   input  wire [4:0]              req_node_y,
   output logic                   rsp_status,
   output logic [15:0]            rsp_low,
   output logic [15:0]            rsp_high,
   output logic [31:0]            rsp_mean,
   output logic [15:0]            rsp_corner_00,
   output logic [15:0]            rsp_corner_10,
   output logic [15:0]            rsp_corner_01,
   output logic [15:0]            rsp_corner_11
);
   import qthb_pkg::*;

   localparam int TB    = $clog2(FIELD_DIM);
   localparam int TOP   = $clog2(FIELD_DIM / LEAF_DIM);
   localparam int NODES = ((4 << (2 * TOP)) - 1) / 3;
   localparam int AW    = $clog2(NODES);
   localparam int LW    = $clog2(TOP + 2);

   // first node of a level: sum of 4^i for every level above it
   function automatic logic [AW-1:0] level_base(input int k);
      logic [AW-1:0] base;
      base = '0;
      for (int i = 0; i < TOP; i++)
         if (i < k) base = base | (AW'(1) << (2 * i));
      return base;
   endfunction

   logic [15:0] min_mem [NODES];
   logic [15:0] max_mem [NODES];
   logic [35:0] sum_mem [NODES];
   logic [63:0] cor_mem [NODES];

   logic [9:0]    px_ff, py_ff;
   logic [15:0]   h_ff;
   logic [2:0]    ql_ff;
   logic [LW-1:0] lvl_ff, lvl_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic [AW-1:0] addr_ff;
   logic [15:0]   rmin_ff, rmax_ff;
   logic [35:0]   rsum_ff;
   logic [63:0]   rcor_ff;
   logic          qbad_ff;
   logic [4:0]    qsb_ff;

   // level-indexed node address for the pending write
   logic [AW-1:0] w_addr;
   logic [TB-1:0] sb;
   logic [TB:0]   nx, ny, lx, ly, smask;
   always_comb begin
      sb    = TB'(TB) - TB'(lvl_ff);
      nx    = (TB+1)'({1'b0, px_ff[TB-1:0]} >> sb);
      ny    = (TB+1)'({1'b0, py_ff[TB-1:0]} >> sb);
      smask = ((TB+1)'(1) << sb) - (TB+1)'(1);
      lx    = (TB+1)'(px_ff[TB-1:0]) & smask;
      ly    = (TB+1)'(py_ff[TB-1:0]) & smask;
      w_addr = level_base(int'(lvl_ff)) + (AW'(ny) << lvl_ff) + AW'(nx);
   end

   // query address
   logic [AW-1:0] q_addr;
   logic          q_bad;
   always_comb begin
      q_bad  = (int'(req_level) > TOP) ||
               (int'(req_node_x) >= (1 << req_level)) ||
               (int'(req_node_y) >= (1 << req_level));
      q_addr = level_base(int'(req_level)) + (AW'(req_node_y) << req_level)
               + AW'(req_node_x);
   end

   always_comb begin
      lvl_in = lvl_ff;
      if (cmd.load) lvl_in = '0;
      else if (cmd.lvl_next) lvl_in = lvl_ff + LW'(1);
      clr_in = clr_ff;
      if (cmd.clr_start) clr_in = '0;
      else if (cmd.clr_step) clr_in = clr_ff + AW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lvl_ff <= '0;
         clr_ff <= '0;
      end else begin
         lvl_ff <= lvl_in;
         clr_ff <= clr_in;
      end
   end

   assign sts.clr_last = (clr_ff == AW'(NODES - 1));
   assign sts.lvl_last = (int'(lvl_ff) == TOP);
   assign sts.pix_ok   = (int'(px_ff) < FIELD_DIM) && (int'(py_ff) < FIELD_DIM);

   // merged values for write back
   logic [15:0] n_min, n_max;
   logic [36:0] sum_wide;
   logic [35:0] n_sum;
   logic [63:0] n_cor;
   logic        cx_lo, cx_hi, cy_lo, cy_hi;
   always_comb begin
      n_min    = (h_ff < rmin_ff) ? h_ff : rmin_ff;
      n_max    = (h_ff > rmax_ff) ? h_ff : rmax_ff;
      sum_wide = {1'b0, rsum_ff} + 37'(h_ff);
      n_sum    = sum_wide[36] ? SUM_MAX : sum_wide[35:0];
      cx_lo = (lx == '0);
      cx_hi = !cx_lo && (lx == smask);
      cy_lo = (ly == '0);
      cy_hi = !cy_lo && (ly == smask);
      n_cor = rcor_ff;
      if (cx_lo && cy_lo) n_cor[15:0]  = h_ff;
      if (cx_hi && cy_lo) n_cor[31:16] = h_ff;
      if (cx_lo && cy_hi) n_cor[47:32] = h_ff;
      if (cx_hi && cy_hi) n_cor[63:48] = h_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         px_ff <= req_pixel_x;
         py_ff <= req_pixel_y;
         h_ff  <= req_height;
         ql_ff <= req_level;
         qbad_ff <= q_bad;
      end
      if (cmd.q_rd) qsb_ff <= 5'(TB - int'(ql_ff));
      if (cmd.clr_step) begin
         min_mem[clr_ff] <= HEIGHT_MAX;
         max_mem[clr_ff] <= '0;
         sum_mem[clr_ff] <= '0;
         cor_mem[clr_ff] <= '0;
      end else if (cmd.wr) begin
         min_mem[addr_ff] <= n_min;
         max_mem[addr_ff] <= n_max;
         sum_mem[addr_ff] <= n_sum;
         cor_mem[addr_ff] <= n_cor;
      end
      if (cmd.rd || cmd.q_rd) begin
         rmin_ff <= min_mem[cmd.rd ? w_addr : addr_ff];
         rmax_ff <= max_mem[cmd.rd ? w_addr : addr_ff];
         rsum_ff <= sum_mem[cmd.rd ? w_addr : addr_ff];
         rcor_ff <= cor_mem[cmd.rd ? w_addr : addr_ff];
      end
      if (cmd.rd) addr_ff <= w_addr;
      else if (cmd.load) addr_ff <= q_addr;
   end

   // average: sum << 16 >> 2*sb, saturate
   logic [67:0] avg_wide;
   logic [31:0] avg;
   always_comb begin
      avg_wide = ({32'd0, rsum_ff} << 16) >> (2 * qsb_ff);
      avg = (avg_wide > 68'(AVG_MAX)) ? AVG_MAX : avg_wide[31:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.q_done) begin
         rsp_status    <= qbad_ff;
         rsp_low       <= qbad_ff ? '0 : rmin_ff;
         rsp_high      <= qbad_ff ? '0 : rmax_ff;
         rsp_mean      <= qbad_ff ? '0 : avg;
         rsp_corner_00 <= qbad_ff ? '0 : rcor_ff[15:0];
         rsp_corner_10 <= qbad_ff ? '0 : rcor_ff[31:16];
         rsp_corner_01 <= qbad_ff ? '0 : rcor_ff[47:32];
         rsp_corner_11 <= qbad_ff ? '0 : rcor_ff[63:48];
      end
   end

endmodule : qthb_datapath
`default_nettype wire

// ===== sv/qthb_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qthb_ctrl
// Sequencer for writes (a read state and a write state per level), queries and clear sweeps.
// ----------------------------------------------------------------------------
module qthb_ctrl (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_stall,
   input  wire [1:0]              req_type,
   output logic                   rsp_valid,
   input  wire                    rsp_stall,
   output qthb_pkg::dp_cmd_type   cmd,
   input  qthb_pkg::dp_sts_type   sts
);
   import qthb_pkg::*;

   typedef enum logic [6:0] {
      S_CLR   = 7'b0000001,
      S_IDLE  = 7'b0000010,
      S_RD    = 7'b0000100,
      S_WR    = 7'b0001000,
      S_QRD   = 7'b0010000,
      S_QFMT  = 7'b0100000,
      S_START = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic      rv_ff, rv_in;
   logic      acc;

   // a held result only blocks the next query at its format step
   assign req_stall = (state_ff != S_IDLE);
   assign acc       = req_valid && !req_stall;
   assign rsp_valid = rv_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      rv_in    = rv_ff && rsp_stall;
      case (state_ff)
         S_CLR: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (acc) begin
               cmd.load = 1'b1;
               case (req_type)
                  REQ_WRITE: state_in = S_START;
                  REQ_QUERY: state_in = S_QRD;
                  REQ_CLEAR: begin
                     cmd.clr_start = 1'b1;
                     state_in      = S_CLR;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_START: state_in = sts.pix_ok ? S_RD : S_IDLE;
         S_RD: begin
            cmd.rd   = 1'b1;
            state_in = S_WR;
         end
         S_WR: begin
            cmd.wr = 1'b1;
            if (sts.lvl_last) state_in = S_IDLE;
            else begin
               cmd.lvl_next = 1'b1;
               state_in     = S_RD;
            end
         end
         S_QRD: begin
            cmd.q_rd = 1'b1;
            state_in = S_QFMT;
         end
         S_QFMT: begin
            if (!rv_ff || !rsp_stall) begin
               cmd.q_done = 1'b1;
               rv_in      = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         rv_ff    <= rv_in;
      end
   end

endmodule : qthb_ctrl
`default_nettype wire

// ===== sv/quadtree_height_bounds.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// quadtree_height_bounds
// Min/max/sum/corner pyramid over a square heightfield with node queries.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  req     | in        | req_valid/req_stall | type, pixel, height, node
//  rsp     | out       | rsp_valid/rsp_stall | status, low, high, mean, corners
//
//  Pixel write: a start step, then one store read and one write per level
//  (six levels). Query: a read step, then a format step that registers the
//  result; next transaction taken back in idle. Clear: a sweep resets each
//  node in turn. After reset the 1365 nodes are swept with req_stall high.
//  A held result stalls a following query at its format step only.
module quadtree_height_bounds (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_stall,
   input  wire [1:0]   req_type,
   input  wire [9:0]   req_pixel_x,
   input  wire [9:0]   req_pixel_y,
   input  wire [15:0]  req_height,
   input  wire [2:0]   req_level,
   input  wire [4:0]   req_node_x,
   input  wire [4:0]   req_node_y,
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic        rsp_status,
   output logic [15:0] rsp_low,
   output logic [15:0] rsp_high,
   output logic [31:0] rsp_mean,
   output logic [15:0] rsp_corner_00,
   output logic [15:0] rsp_corner_10,
   output logic [15:0] rsp_corner_01,
   output logic [15:0] rsp_corner_11
);
   import qthb_pkg::*;

   dp_cmd_type cmd;
   dp_sts_type sts;

   qthb_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .req_type,
      .rsp_valid, .rsp_stall, .cmd, .sts
   );

   qthb_datapath u_dp (
      .clock, .reset, .cmd, .sts,
      .req_pixel_x, .req_pixel_y, .req_height, .req_level, .req_node_x, .req_node_y,
      .rsp_status, .rsp_low, .rsp_high, .rsp_mean,
      .rsp_corner_00, .rsp_corner_10, .rsp_corner_01, .rsp_corner_11
   );

endmodule : quadtree_height_bounds
`default_nettype wire

// ===== sv/qthb_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qthb_checker
// Port-level checks for quadtree_height_bounds.
// ----------------------------------------------------------------------------
module qthb_checker (
   input wire        clock,
   input wire        reset,
   input wire        req_stall,
   input wire        rsp_valid,
   input wire        rsp_stall,
   input wire        rsp_status,
   input wire [15:0] rsp_low,
   input wire [31:0] rsp_mean
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_low))
      else $error("result dropped while stalled");
   a_rsp_hold_mean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_status) && $stable(rsp_mean))
      else $error("result changed while stalled");
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> rsp_low == 16'd0 && rsp_mean == 32'd0)
      else $error("bad node result not zeroed");
   a_reset_sweep: assert property (@(posedge clock)
      !reset && $past(reset) |-> req_stall)
      else $error("accepting during reset sweep");
endmodule : qthb_checker

bind quadtree_height_bounds qthb_checker u_qthb_checker (
   .clock, .reset, .req_stall, .rsp_valid, .rsp_stall,
   .rsp_status, .rsp_low, .rsp_mean
);
`default_nettype wire

// ===== bench/quadtree_height_bounds_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadtree_height_bounds_test
// Self-checking bench: pixel writes, node queries and clears are pushed
// through the request channel while a local pyramid predicts each query.
// ----------------------------------------------------------------------------
module quadtree_height_bounds_test;
   import qthb_pkg::*;

   localparam int TSIZE  = 1024;
   localparam int TOPLVL = 5;
   localparam int NODES  = 1365;
   localparam int LIMIT  = 2000000;

   typedef struct packed {
      logic        status;
      logic [15:0] mn;
      logic [15:0] mx;
      logic [31:0] avg;
      logic [15:0] c00;
      logic [15:0] c10;
      logic [15:0] c01;
      logic [15:0] c11;
   } answer_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0] req_type = REQ_WRITE;
   logic [9:0] req_pixel_x = '0, req_pixel_y = '0;
   logic [15:0] req_height = '0;
   logic [2:0] req_level = '0;
   logic [4:0] req_node_x = '0, req_node_y = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_status;
   logic [15:0] rsp_low, rsp_high;
   logic [31:0] rsp_mean;
   logic [15:0] rsp_corner_00, rsp_corner_10, rsp_corner_01, rsp_corner_11;

   quadtree_height_bounds u_dut (.*);

   // local copy of the pyramid
   logic [15:0] pyr_min[NODES];
   logic [15:0] pyr_max[NODES];
   logic [35:0] pyr_sum[NODES];
   logic [63:0] pyr_corner[NODES];

   answer_type pending_answers[$];
   int errors = 0;
   int answers_seen = 0;
   int cycles = 0;
   int sends = 0;
   bit quiet_sender = 1'b0;   // no random idling on the request side
   bit quiet_receiver = 1'b0;
   bit hold_receiver = 1'b0;

   initial forever #10 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("status: fail");
         $finish;
      end
   end

   function automatic int node_index(int lv, int nx, int ny);
      return ((1 << (2 * lv)) - 1) / 3 + (ny << lv) + nx;
   endfunction

   function automatic void clear_pyramid();
      for (int i = 0; i < NODES; i++) begin
         pyr_min[i] = HEIGHT_MAX;
         pyr_max[i] = '0;
         pyr_sum[i] = '0;
         pyr_corner[i] = '0;
      end
   endfunction

   function automatic void merge_pixel(int px, int py, logic [15:0] h);
      int sb, s, idx, lx, ly, cx, cy;
      logic [36:0] acc;
      if (px >= TSIZE || py >= TSIZE) return;
      for (int k = 0; k <= TOPLVL; k++) begin
         sb = 10 - k;
         s = 1 << sb;
         idx = node_index(k, px >> sb, py >> sb);
         lx = px & (s - 1);
         ly = py & (s - 1);
         if (h < pyr_min[idx]) pyr_min[idx] = h;
         if (h > pyr_max[idx]) pyr_max[idx] = h;
         acc = {1'b0, pyr_sum[idx]} + h;
         pyr_sum[idx] = (acc > {1'b0, SUM_MAX}) ? SUM_MAX : acc[35:0];
         cx = (lx == 0) ? 0 : (lx == s - 1) ? 1 : -1;
         cy = (ly == 0) ? 0 : (ly == s - 1) ? 1 : -1;
         if (cx >= 0 && cy >= 0)
            pyr_corner[idx][16 * (cx + 2 * cy) +: 16] = h;
      end
   endfunction

   function automatic answer_type lookup_node(int lv, int nx, int ny);
      answer_type a;
      int idx;
      logic [63:0] wide;
      a = '0;
      if (lv > TOPLVL || nx >= (1 << lv) || ny >= (1 << lv)) begin
         a.status = 1'b1;
         return a;
      end
      idx = node_index(lv, nx, ny);
      wide = ({28'd0, pyr_sum[idx]} << 16) >> (2 * (10 - lv));
      a.mn = pyr_min[idx];
      a.mx = pyr_max[idx];
      a.avg = (wide > {32'd0, AVG_MAX}) ? AVG_MAX : wide[31:0];
      {a.c11, a.c01, a.c10, a.c00} = pyr_corner[idx];
      return a;
   endfunction

   // send one transaction and update the prediction on acceptance;
   // valid stays up until the next call or drain() changes it
   task automatic send_request(logic [1:0] t, int px, int py, int h, int lv, int nx, int ny);
      while (!quiet_sender && $urandom_range(99) < 8) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= t;
      req_pixel_x <= 10'(px);
      req_pixel_y <= 10'(py);
      req_height <= 16'(h);
      req_level <= 3'(lv);
      req_node_x <= 5'(nx);
      req_node_y <= 5'(ny);
      do @(posedge clock); while (req_stall);
      sends++;
      if (t == REQ_WRITE) merge_pixel(px, py, h[15:0]);
      else if (t == REQ_QUERY) pending_answers.push_back(lookup_node(lv, nx, ny));
      else if (t == REQ_CLEAR) clear_pyramid();
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // receiver stall generator
   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= hold_receiver || (!quiet_receiver && $urandom_range(99) < 8);
   end

   always @(posedge clock) begin
      answer_type got, want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_status, rsp_low, rsp_high, rsp_mean,
                 rsp_corner_00, rsp_corner_10, rsp_corner_01, rsp_corner_11};
         answers_seen++;
         if (pending_answers.size() == 0) begin
            $error("unexpected response");
            errors++;
         end else begin
            want = pending_answers.pop_front();
            if (got.status !== want.status) begin
               $error("status exp %0d got %0d", want.status, got.status); errors++; end
            if (got.mn !== want.mn) begin
               $error("rsp_low exp %0d got %0d", want.mn, got.mn); errors++; end
            if (got.mx !== want.mx) begin
               $error("rsp_high exp %0d got %0d", want.mx, got.mx); errors++; end
            if (got.avg !== want.avg) begin
               $error("rsp_mean exp %0h got %0h", want.avg, got.avg); errors++; end
            if (got.c00 !== want.c00) begin
               $error("corner_00 exp %0d got %0d", want.c00, got.c00); errors++; end
            if (got.c10 !== want.c10) begin
               $error("corner_10 exp %0d got %0d", want.c10, got.c10); errors++; end
            if (got.c01 !== want.c01) begin
               $error("corner_01 exp %0d got %0d", want.c01, got.c01); errors++; end
            if (got.c11 !== want.c11) begin
               $error("corner_11 exp %0d got %0d", want.c11, got.c11); errors++; end
         end
      end
   end

   task automatic random_query();
      int lv;
      lv = $urandom_range(TOPLVL);
      send_request(REQ_QUERY, 0, 0, 0, lv, $urandom_range((1 << lv) - 1),
                   $urandom_range((1 << lv) - 1));
   endtask

   task automatic test_directed();
      // untouched nodes, bad nodes and ignored requests
      send_request(REQ_QUERY, 0, 0, 0, 0, 0, 0);
      send_request(REQ_QUERY, 0, 0, 0, 5, 31, 31);
      send_request(REQ_QUERY, 0, 0, 0, 6, 0, 0);
      send_request(REQ_QUERY, 0, 0, 0, 7, 31, 31);
      send_request(REQ_QUERY, 0, 0, 0, 1, 2, 0);
      send_request(REQ_QUERY, 0, 0, 0, 2, 0, 4);
      send_request(REQ_NOP, 5, 5, 100, 0, 0, 0);
      // corner pixels with extreme heights
      send_request(REQ_WRITE, 0, 0, 16'hFFFF, 0, 0, 0);
      send_request(REQ_WRITE, 1023, 0, 0, 0, 0, 0);
      send_request(REQ_WRITE, 0, 1023, 16'h5555, 0, 0, 0);
      send_request(REQ_WRITE, 1023, 1023, 16'hAAAA, 0, 0, 0);
      send_request(REQ_WRITE, 31, 32, 1234, 0, 0, 0);
      send_request(REQ_WRITE, 0, 0, 7, 0, 0, 0);   // written twice
      send_request(REQ_QUERY, 0, 0, 0, 0, 0, 0);
      send_request(REQ_QUERY, 0, 0, 0, 5, 0, 0);
      send_request(REQ_QUERY, 0, 0, 0, 5, 31, 31);
      send_request(REQ_QUERY, 0, 0, 0, 5, 0, 1);
      send_request(REQ_QUERY, 0, 0, 0, 3, 7, 0);
      send_request(REQ_CLEAR, 0, 0, 0, 0, 0, 0);
      send_request(REQ_QUERY, 0, 0, 0, 0, 0, 0);
      drain();
   endtask

   // fill one chunk with 300 writes, every third one at full-scale height
   task automatic test_chunk_fill();
      int bx, by;
      bx = 32 * $urandom_range(31);
      by = 32 * $urandom_range(31);
      for (int i = 0; i < 300; i++)
         send_request(REQ_WRITE, bx + $urandom_range(31), by + $urandom_range(31),
                      (i % 3 == 0) ? 16'hFFFF : $urandom_range(65535), 0, 0, 0);
      send_request(REQ_QUERY, 0, 0, 0, 5, bx / 32, by / 32);
      send_request(REQ_QUERY, 0, 0, 0, 4, bx / 64, by / 64);
      send_request(REQ_QUERY, 0, 0, 0, 0, 0, 0);
   endtask

   task automatic test_random_mix(int n, bit calm);
      int r, px, py;
      quiet_sender = calm;
      quiet_receiver = calm;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(99);
         if (r < 60) begin
            // bias toward node corners and field edges
            px = ($urandom_range(3) == 0) ? (32 * $urandom_range(31) + 31 * $urandom_range(1))
                                          : $urandom_range(1023);
            py = ($urandom_range(3) == 0) ? (32 * $urandom_range(31) + 31 * $urandom_range(1))
                                          : $urandom_range(1023);
            send_request(REQ_WRITE, px, py, $urandom_range(65535), 0, 0, 0);
         end else if (r < 93) random_query();
         else if (r < 95)
            send_request(REQ_QUERY, 0, 0, 0, $urandom_range(7), $urandom_range(31),
                         $urandom_range(31));
         else if (r < 98) send_request(REQ_NOP, $urandom_range(1023), $urandom_range(1023),
                                       $urandom_range(65535), $urandom_range(7),
                                       $urandom_range(31), $urandom_range(31));
         else send_request(REQ_CLEAR, 0, 0, 0, 0, 0, 0);
      end
      quiet_sender = 1'b0;
      quiet_receiver = 1'b0;
   endtask

   // hold the receiver for a long stretch while queries keep coming
   task automatic test_backpressure();
      fork
         begin
            hold_receiver = 1'b1;
            repeat (400) @(posedge clock);
            hold_receiver = 1'b0;
         end
         for (int i = 0; i < 20; i++) random_query();
      join
      drain();
   endtask

   initial begin
      clear_pyramid();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_chunk_fill();
      drain();
      test_random_mix(400, 1'b0);
      test_backpressure();
      test_random_mix(250, 1'b1);
      test_random_mix(400, 1'b0);
      drain();
      $display("covered %0d requests and %0d query responses,", sends, answers_seen);
      $display("including bad nodes, clears, ignored types and a long response hold");
      if (errors == 0 && pending_answers.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

// ===== files.f =====
sv/qthb_pkg.sv
sv/qthb_datapath.sv
sv/qthb_ctrl.sv
sv/quadtree_height_bounds.sv
sv/qthb_checker.sv
bench/quadtree_height_bounds_test.sv
